/* src/spr_pkg.sv */
// Shared types and constants for the septet packet receiver.
`default_nettype none

package spr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_FRAME  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BIT7      = 3'd1,
    ERR_HDR_SUM   = 3'd2,
    ERR_FRAME_SUM = 3'd3,
    ERR_TIMEOUT   = 3'd4
  } err_t;

  // Configuration register indexes.
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_ACCEPT  = 1'b1;

  localparam logic [19:0] TIMEOUT_RESET = 20'd20000;
  localparam logic [15:0] ACCEPT_RESET  = 16'h0100;
  localparam logic [19:0] TICK_MAX      = 20'hFFFFF;

  localparam logic [7:0] SYNC_BYTE    = 8'hAA;
  localparam logic [6:0] SUM_INIT     = 7'h7F;
  localparam logic [3:0] PROTO_V1     = 4'd1;
  localparam logic [3:0] HDR_LAST_POS = 4'd8;
  localparam logic [3:0] SEPTET_POS   = 4'd4;
  localparam logic [3:0] DATA_BYTES   = 4'd4;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [2:0]  error_code;
    logic [15:0] dst_addr;
    logic [15:0] src_addr;
    logic [15:0] command;
    logic [6:0]  frame_count;
    logic [6:0]  frame_index;
    logic [31:0] payload;
  } out_item_t;

endpackage

`default_nettype wire

/* src/septet_packet_receiver_unit.sv */
// Top level of the septet packet receiver: sync hunt, header, frames, timeout.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        sink       in_valid / in_stall       spr_pkg::in_item_t  (byte or tick)
// out       source     out_valid / out_stall     spr_pkg::out_item_t (header, frame, error)
// cfg       sink       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item is taken per cycle unless in_stall is high; its result, if any, sits in the
// output register from the next cycle on. The whole per-item decode is one stage of
// logic between the state registers and the output register.
// in_stall is high only while the output register holds an item that is stalled.
// Synchronous reset returns the receiver to hunting and loads the register
// defaults; cfg_ready is always high.

module septet_packet_receiver_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire spr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output spr_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [19:0]        cfg_data
);

  // Configuration.
  logic [19:0] timeout_ticks;
  logic [15:0] accept_command;

  // Receiver state.
  spr_pkg::phase_t phase, phase_next;
  logic [3:0]  byte_pos, byte_pos_next;
  logic [6:0]  frames_seen, frames_seen_next;
  logic [6:0]  frames_total, frames_total_next;
  logic [15:0] dst_reg, dst_reg_next;
  logic [15:0] src_reg, src_reg_next;
  logic [15:0] cmd_reg, cmd_reg_next;
  logic [3:0]  protocol_reg, protocol_reg_next;
  logic [6:0]  running_sum, running_sum_next;
  logic [31:0] data_shift, data_shift_next;
  logic [19:0] elapsed_ticks, elapsed_ticks_next;
  logic        timed_out, timed_out_next;

  logic                accept;
  logic                res_valid;
  spr_pkg::out_item_t  res_item;

  // Shared decode of the current item.
  logic [7:0]  b;
  logic        is_tick;
  logic        in_pkt;
  logic        is_sync;
  logic [6:0]  sum_new;
  logic        sum_ok;
  logic [19:0] tick_inc;
  logic        tick_fire;
  logic [6:0]  seen_inc;
  logic        hdr_end;
  logic        frm_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  assign b         = in_data.rx_byte;
  assign is_tick   = in_data.mode;
  assign in_pkt    = (phase == spr_pkg::PH_HEADER) || (phase == spr_pkg::PH_FRAME);
  assign is_sync   = (b == spr_pkg::SYNC_BYTE);
  assign sum_new   = running_sum - b[6:0];
  assign sum_ok    = (sum_new == 7'd0);
  assign tick_inc  = (elapsed_ticks == spr_pkg::TICK_MAX) ? elapsed_ticks
                                                           : elapsed_ticks + 20'd1;
  assign tick_fire = (tick_inc > timeout_ticks) && !timed_out;
  assign seen_inc  = frames_seen + 7'd1;
  assign hdr_end   = (phase == spr_pkg::PH_HEADER) && (byte_pos == spr_pkg::HDR_LAST_POS);
  assign frm_end   = (phase == spr_pkg::PH_FRAME) && (byte_pos > spr_pkg::SEPTET_POS);

  // Next-state logic.
  always_comb begin
    phase_next        = phase;
    byte_pos_next     = byte_pos;
    frames_seen_next  = frames_seen;
    frames_total_next = frames_total;
    dst_reg_next      = dst_reg;
    src_reg_next      = src_reg;
    cmd_reg_next      = cmd_reg;
    protocol_reg_next = protocol_reg;
    running_sum_next  = running_sum;
    data_shift_next   = data_shift;
    elapsed_ticks_next = elapsed_ticks;
    timed_out_next    = timed_out;

    if (is_tick) begin
      elapsed_ticks_next = tick_inc;
      if (tick_fire) begin
        timed_out_next = 1'b1;
        phase_next     = spr_pkg::PH_HUNT;
      end
    end else if (!in_pkt || b[7]) begin
      // Hunting, or a stray high bit that aborts the packet; a sync byte restarts.
      phase_next = spr_pkg::PH_HUNT;
      if (is_sync) begin
        phase_next        = spr_pkg::PH_HEADER;
        byte_pos_next     = 4'd0;
        running_sum_next  = spr_pkg::SUM_INIT;
        dst_reg_next      = 16'd0;
        src_reg_next      = 16'd0;
        cmd_reg_next      = 16'd0;
        protocol_reg_next = 4'd0;
        frames_total_next = 7'd0;
        frames_seen_next  = 7'd0;
        data_shift_next   = 32'd0;
      end
    end else begin
      running_sum_next = sum_new;
      if (phase == spr_pkg::PH_HEADER) begin
        if (!hdr_end) begin
          byte_pos_next = byte_pos + 4'd1;
          unique case (byte_pos)
            4'd0:    dst_reg_next      = {8'd0, b};
            4'd1:    dst_reg_next      = {b, dst_reg[7:0]};
            4'd2:    src_reg_next      = {8'd0, b};
            4'd3:    src_reg_next      = {b, src_reg[7:0]};
            4'd4:    protocol_reg_next = b[7:4];
            4'd5:    cmd_reg_next      = {8'd0, b};
            4'd6:    cmd_reg_next      = {b, cmd_reg[7:0]};
            4'd7:    frames_total_next = b[6:0];
            default: ;
          endcase
        end else if (protocol_reg != spr_pkg::PROTO_V1 || !sum_ok) begin
          phase_next = spr_pkg::PH_HUNT;
        end else if (cmd_reg != accept_command || frames_total == 7'd0) begin
          // Packet complete: either ignored command or a header with no frames.
          phase_next         = spr_pkg::PH_HUNT;
          elapsed_ticks_next = 20'd0;
          timed_out_next     = 1'b0;
        end else begin
          phase_next       = spr_pkg::PH_FRAME;
          byte_pos_next    = 4'd0;
          frames_seen_next = 7'd0;
          running_sum_next = spr_pkg::SUM_INIT;
          data_shift_next  = 32'd0;
        end
      end else begin
        if (byte_pos < spr_pkg::DATA_BYTES) begin
          data_shift_next[8*byte_pos[1:0] +: 8] = {1'b0, b[6:0]};
          byte_pos_next = byte_pos + 4'd1;
        end else if (byte_pos == spr_pkg::SEPTET_POS) begin
          // The septet byte carries the stripped bit 7 of each data byte.
          data_shift_next = data_shift | {b[3], 7'd0, b[2], 7'd0, b[1], 7'd0, b[0], 7'd0};
          byte_pos_next   = byte_pos + 4'd1;
        end else if (!sum_ok) begin
          phase_next = spr_pkg::PH_HUNT;
        end else begin
          frames_seen_next = seen_inc;
          if (seen_inc == frames_total) begin
            phase_next         = spr_pkg::PH_HUNT;
            elapsed_ticks_next = 20'd0;
            timed_out_next     = 1'b0;
          end else begin
            byte_pos_next    = 4'd0;
            running_sum_next = spr_pkg::SUM_INIT;
            data_shift_next  = 32'd0;
          end
        end
      end
    end
  end

  // Result logic.
  always_comb begin
    res_valid = 1'b0;
    res_item  = '0;
    if (is_tick) begin
      if (tick_fire) begin
        res_valid           = 1'b1;
        res_item.kind       = spr_pkg::KIND_ERROR;
        res_item.error_code = spr_pkg::ERR_TIMEOUT;
      end
    end else if (in_pkt) begin
      if (b[7]) begin
        res_valid           = 1'b1;
        res_item.kind       = spr_pkg::KIND_ERROR;
        res_item.error_code = spr_pkg::ERR_BIT7;
      end else if (hdr_end && protocol_reg == spr_pkg::PROTO_V1) begin
        if (!sum_ok) begin
          res_valid           = 1'b1;
          res_item.kind       = spr_pkg::KIND_ERROR;
          res_item.error_code = spr_pkg::ERR_HDR_SUM;
        end else if (cmd_reg == accept_command) begin
          res_valid            = 1'b1;
          res_item.kind        = spr_pkg::KIND_HEADER;
          res_item.last        = (frames_total == 7'd0);
          res_item.dst_addr    = dst_reg;
          res_item.src_addr    = src_reg;
          res_item.command     = cmd_reg;
          res_item.frame_count = frames_total;
        end
      end else if (frm_end) begin
        res_valid = 1'b1;
        if (!sum_ok) begin
          res_item.kind       = spr_pkg::KIND_ERROR;
          res_item.error_code = spr_pkg::ERR_FRAME_SUM;
        end else begin
          res_item.kind        = spr_pkg::KIND_FRAME;
          res_item.last        = (seen_inc == frames_total);
          res_item.dst_addr    = dst_reg;
          res_item.src_addr    = src_reg;
          res_item.command     = cmd_reg;
          res_item.frame_count = frames_total;
          res_item.frame_index = frames_seen;
          res_item.payload     = data_shift;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= spr_pkg::TIMEOUT_RESET;
      accept_command <= spr_pkg::ACCEPT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spr_pkg::CFG_TIMEOUT: timeout_ticks  <= cfg_data;
        spr_pkg::CFG_ACCEPT:  accept_command <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= spr_pkg::PH_HUNT;
      byte_pos      <= 4'd0;
      frames_seen   <= 7'd0;
      frames_total  <= 7'd0;
      dst_reg       <= 16'd0;
      src_reg       <= 16'd0;
      cmd_reg       <= 16'd0;
      protocol_reg  <= 4'd0;
      running_sum   <= spr_pkg::SUM_INIT;
      data_shift    <= 32'd0;
      elapsed_ticks <= 20'd0;
      timed_out     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_pos      <= byte_pos_next;
      frames_seen   <= frames_seen_next;
      frames_total  <= frames_total_next;
      dst_reg       <= dst_reg_next;
      src_reg       <= src_reg_next;
      cmd_reg       <= cmd_reg_next;
      protocol_reg  <= protocol_reg_next;
      running_sum   <= running_sum_next;
      data_shift    <= data_shift_next;
      elapsed_ticks <= elapsed_ticks_next;
      timed_out     <= timed_out_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data <= res_item;
    end
  end

  // An error item carries nothing but its code.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == spr_pkg::KIND_ERROR |->
      !out_data.last && out_data.payload == 32'd0 && out_data.error_code != spr_pkg::ERR_NONE)
    else $error("error item with stray fields");

  // Frame phase is only entered with frames still to come.
  a_frame_total: assert property (@(posedge clk) disable iff (rst)
    phase == spr_pkg::PH_FRAME |-> frames_total != 7'd0 && byte_pos <= 4'd5)
    else $error("frame phase without frames");

  // The header position never passes the checksum byte.
  a_hdr_pos: assert property (@(posedge clk) disable iff (rst)
    phase == spr_pkg::PH_HEADER |-> byte_pos <= spr_pkg::HDR_LAST_POS)
    else $error("header position overrun");

  // After a timeout item, the receiver is back to hunting.
  a_timeout_hunt: assert property (@(posedge clk) disable iff (rst)
    accept && is_tick && tick_fire |=> phase == spr_pkg::PH_HUNT && timed_out)
    else $error("timeout did not drop the packet");

endmodule

`default_nettype wire
